### rtl/core/ftpep_pkg.sv
// Shared constants, types and helper functions for the extended-port parser.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ftpep_pkg;

   // Parse phases
   localparam logic [2:0] PH_DELIM  = 3'd0;
   localparam logic [2:0] PH_FAMILY = 3'd1;
   localparam logic [2:0] PH_OCTETS = 3'd2;
   localparam logic [2:0] PH_TAIL   = 3'd3;
   localparam logic [2:0] PH_PORT   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;
   localparam logic [2:0] PH_FAILED = 3'd6;
   localparam logic [2:0] PH_DRAIN  = 3'd7;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SYNTAX  = 2'd1;
   localparam logic [1:0] ST_FAMILY  = 2'd2;
   localparam logic [1:0] ST_HANDOFF = 2'd3;

   // Octet separator kinds
   localparam logic [1:0] SEP_NONE  = 2'd0;
   localparam logic [1:0] SEP_COMMA = 2'd1;
   localparam logic [1:0] SEP_DOT   = 2'd2;

   // Characters
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   // Limits
   localparam logic [16:0] ACC_MAX    = 17'd131071;
   localparam logic [16:0] OCTET_MAX  = 17'd255;
   localparam logic [16:0] PORT_MAX   = 17'd65535;
   localparam logic [16:0] FAMILY_MAX = 17'd255;
   localparam logic [7:0]  FAMILY_V4  = 8'd1;
   localparam logic [7:0]  FAMILY_V6  = 8'd2;

   // Queue between the classifier and the parser
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   // One classified byte
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       is_zero;
      logic       is_digit;
      logic       is_sep;
      logic       is_comma;
      logic [3:0] digit;
   } item_type;

   // Queue fill status
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // acc * 10 + digit, saturating at lim
   function automatic logic [16:0] acc_mac(input logic [16:0] acc,
                                           input logic [3:0]  dig,
                                           input logic [16:0] lim);
      logic [20:0] v;
      v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {17'd0, dig};
      return (v > {4'd0, lim}) ? lim : v[16:0];
   endfunction

endpackage

`default_nettype wire

### rtl/core/ftpep_if.sv
// Valid/ready channel interfaces of the extended-port parser.
// Depends on nothing; used by the front end, the back end and the top level.
`default_nettype none

// Input text channel
interface ftpep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;
   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// Result channel
interface ftpep_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] ipv4_address;
   logic [15:0] port_number;
   modport source (output valid, output status, output ipv4_address,
                   output port_number, input ready);
   modport sink   (input valid, input status, input ipv4_address,
                   input port_number, output ready);
endinterface

// Configuration write channel
interface ftpep_csr_if;
   logic valid;
   logic ready;
   logic v6_enabled;
   modport source (output valid, output v6_enabled, input ready);
   modport sink   (input valid, input v6_enabled, output ready);
endinterface

`default_nettype wire

### rtl/core/ftpep_front.sv
// Front end: accepts text bytes and classifies each into a queue item.
// Depends on ftpep_pkg and ftpep_req_if.
`default_nettype none

module ftpep_front
   import ftpep_pkg::*;
(
   ftpep_req_if.sink    req_port,
   input  q_status_type q_status,
   output logic         push,
   output item_type     push_item
);

   // Accept whenever the queue has room
   assign req_port.ready = !q_status.full;
   assign push           = req_port.valid && !q_status.full;

   // Character classes
   always_comb begin
      push_item.text_byte = req_port.text_byte;
      push_item.last_byte = req_port.last_byte;
      push_item.is_zero   = (req_port.text_byte == 8'd0);
      push_item.is_digit  = (req_port.text_byte >= CH_ZERO) &&
                            (req_port.text_byte <= CH_NINE);
      push_item.is_comma  = (req_port.text_byte == CH_COMMA);
      push_item.is_sep    = (req_port.text_byte == CH_COMMA) ||
                            (req_port.text_byte == CH_DOT);
      push_item.digit     = req_port.text_byte[3:0];
   end

endmodule

`default_nettype wire

### rtl/core/ftpep_queue.sv
// Short FIFO of classified items between the front end and the parser.
// Depends on ftpep_pkg.
`default_nettype none

module ftpep_queue
   import ftpep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  item_type     push_item,
   input  logic         pop,
   output item_type     pop_item,
   output q_status_type q_status
);

   localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
   localparam logic [Q_PTR_W:0]   CNT_FULL = (Q_PTR_W + 1)'(Q_DEPTH);

   item_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]    count_ff, count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_FULL);
   assign pop_item       = mem_ff[rd_ptr_ff];

   // Pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ftpep_back.sv
// Back end: parser state machine, config register and result register.
// Depends on ftpep_pkg, ftpep_rsp_if and ftpep_csr_if.
`default_nettype none

module ftpep_back
   import ftpep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ftpep_rsp_if.source  rsp_port,
   ftpep_csr_if.sink    csr_port,
   input  q_status_type q_status,
   input  item_type     pop_item,
   output logic         pop
);

   logic        v6_en_ff;
   logic [2:0]  phase_ff,     phase_in;
   logic [7:0]  delim_ff,     delim_in;
   logic [7:0]  family_ff,    family_in;
   logic [1:0]  oct_idx_ff,   oct_idx_in;
   logic [1:0]  sep_kind_ff,  sep_kind_in;
   logic [16:0] accum_ff,     accum_in;
   logic [31:0] addr_ff,      addr_in;
   logic [1:0]  fail_ff,      fail_in;
   logic        dseen_ff,     dseen_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff,    status_in;
   logic [31:0] rsp_addr_ff,  rsp_addr_in;
   logic [15:0] rsp_port_ff,  rsp_port_in;

   logic        produce;
   logic        commit_ok;
   logic [31:0] commit_addr;
   logic [1:0]  kind;
   logic        is_delim;

   // Config register; always ready
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_en_ff <= 1'b0;
      end else if (csr_port.valid) begin
         v6_en_ff <= csr_port.v6_enabled;
      end
   end

   // Helpers for the octet commit
   assign commit_ok   = dseen_ff && (accum_ff <= OCTET_MAX);
   assign commit_addr = {addr_ff[23:0], accum_ff[7:0]};
   assign kind        = pop_item.is_comma ? SEP_COMMA : SEP_DOT;
   assign is_delim    = (pop_item.text_byte == delim_ff);

   // Result only at end of text outside drain
   assign produce = (phase_ff != PH_DRAIN) && (pop_item.is_zero || pop_item.last_byte);
   assign pop     = !q_status.empty && (!produce || !rsp_valid_ff || rsp_port.ready);

   // Parser next state
   always_comb begin
      phase_in    = phase_ff;
      delim_in    = delim_ff;
      family_in   = family_ff;
      oct_idx_in  = oct_idx_ff;
      sep_kind_in = sep_kind_ff;
      accum_in    = accum_ff;
      addr_in     = addr_ff;
      fail_in     = fail_ff;
      dseen_in    = dseen_ff;
      status_in   = ST_SYNTAX;
      rsp_addr_in = '0;
      rsp_port_in = '0;

      // consume a nonzero byte
      if (!pop_item.is_zero) begin
         case (phase_ff)
            PH_DELIM: begin
               if (pop_item.is_digit || pop_item.is_sep) begin
                  fail_in  = ST_SYNTAX;
                  phase_in = PH_FAILED;
               end else begin
                  delim_in = pop_item.text_byte;
                  phase_in = PH_FAMILY;
               end
            end
            PH_FAMILY: begin
               if (pop_item.is_digit) begin
                  family_in = 8'(acc_mac({9'd0, family_ff}, pop_item.digit, FAMILY_MAX));
               end else if (is_delim) begin
                  if ((family_ff == FAMILY_V6) && v6_en_ff) begin
                     fail_in  = ST_HANDOFF;
                     phase_in = PH_FAILED;
                  end else if (family_ff != FAMILY_V4) begin
                     fail_in  = ST_FAMILY;
                     phase_in = PH_FAILED;
                  end else begin
                     phase_in = PH_OCTETS;
                  end
               end else begin
                  fail_in  = ST_SYNTAX;
                  phase_in = PH_FAILED;
               end
            end
            PH_OCTETS: begin
               if (pop_item.is_digit) begin
                  accum_in = acc_mac(accum_ff, pop_item.digit, ACC_MAX);
                  dseen_in = 1'b1;
               end else if (pop_item.is_sep && (oct_idx_ff != 2'd3) &&
                            (sep_kind_ff != SEP_NONE) && (sep_kind_ff != kind)) begin
                  fail_in  = ST_SYNTAX;
                  phase_in = PH_FAILED;
               end else if (pop_item.is_sep || (is_delim && (oct_idx_ff == 2'd3))) begin
                  if (!commit_ok) begin
                     fail_in  = ST_SYNTAX;
                     phase_in = PH_FAILED;
                  end else begin
                     addr_in    = commit_addr;
                     oct_idx_in = oct_idx_ff + 1'b1;
                     accum_in   = '0;
                     dseen_in   = 1'b0;
                     if (pop_item.is_sep) begin
                        if (oct_idx_ff == 2'd3) begin
                           phase_in = PH_TAIL;
                        end else begin
                           sep_kind_in = kind;
                        end
                     end else if (commit_addr == '0) begin
                        fail_in  = ST_SYNTAX;
                        phase_in = PH_FAILED;
                     end else begin
                        phase_in = PH_PORT;
                     end
                  end
               end else begin
                  fail_in  = ST_SYNTAX;
                  phase_in = PH_FAILED;
               end
            end
            PH_TAIL: begin
               if (pop_item.is_digit || pop_item.is_sep) begin
                  phase_in = PH_TAIL;
               end else if (is_delim && (addr_ff != '0)) begin
                  accum_in = '0;
                  phase_in = PH_PORT;
               end else begin
                  fail_in  = ST_SYNTAX;
                  phase_in = PH_FAILED;
               end
            end
            PH_PORT: begin
               if (pop_item.is_digit) begin
                  accum_in = acc_mac(accum_ff, pop_item.digit, ACC_MAX);
               end else if (is_delim && (accum_ff != '0) && (accum_ff <= PORT_MAX)) begin
                  phase_in = PH_DONE;
               end else begin
                  fail_in  = ST_SYNTAX;
                  phase_in = PH_FAILED;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // end of text: form result, then clear
      if (produce) begin
         if (phase_in == PH_DONE) begin
            status_in   = ST_OK;
            rsp_addr_in = addr_in;
            rsp_port_in = accum_in[15:0];
         end else if (phase_in == PH_FAILED) begin
            status_in = fail_in;
         end
      end

      if (produce || ((phase_ff == PH_DRAIN) && pop_item.last_byte)) begin
         phase_in    = (pop_item.last_byte) ? PH_DELIM : PH_DRAIN;
         delim_in    = '0;
         family_in   = '0;
         oct_idx_in  = '0;
         sep_kind_in = SEP_NONE;
         accum_in    = '0;
         addr_in     = '0;
         fail_in     = ST_OK;
         dseen_in    = 1'b0;
      end else if (phase_ff == PH_DRAIN) begin
         phase_in = PH_DRAIN;
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_DELIM;
         delim_ff    <= '0;
         family_ff   <= '0;
         oct_idx_ff  <= '0;
         sep_kind_ff <= SEP_NONE;
         accum_ff    <= '0;
         addr_ff     <= '0;
         fail_ff     <= ST_OK;
         dseen_ff    <= 1'b0;
      end else if (pop) begin
         phase_ff    <= phase_in;
         delim_ff    <= delim_in;
         family_ff   <= family_in;
         oct_idx_ff  <= oct_idx_in;
         sep_kind_ff <= sep_kind_in;
         accum_ff    <= accum_in;
         addr_ff     <= addr_in;
         fail_ff     <= fail_in;
         dseen_ff    <= dseen_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && produce) begin
         status_ff   <= status_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_port_ff <= rsp_port_in;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = status_ff;
   assign rsp_port.ipv4_address = rsp_addr_ff;
   assign rsp_port.port_number  = rsp_port_ff;

endmodule

`default_nettype wire

### rtl/core/ftp_extended_port_parser.sv
// Top level of the extended-port argument parser.
// Depends on ftpep_pkg, ftpep_if, ftpep_front, ftpep_queue and ftpep_back.
//
//   channel   dir  handshake          payload
//   req_port  in   valid/ready        text_byte[7:0], last_byte
//   rsp_port  out  valid/ready        status[1:0], ipv4_address[31:0], port_number[15:0]
//   csr_port  in   valid/ready        v6_enabled
//
// One byte per cycle sustained unless a result stalls; the parser state machine consumes one
// queued item per cycle but holds an item that ends a text while the last result waits. The
// byte that ends a text is stored in the queue, then popped into the result register.
// Reset (synchronous) empties the queue, clears parser state and sets v6_enabled to 0.
// A stalled result holds only the items that end a text; a four-entry queue absorbs input.
// csr_port is always ready.
`default_nettype none

module ftp_extended_port_parser
   import ftpep_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   ftpep_req_if.sink    req_port,
   ftpep_rsp_if.source  rsp_port,
   ftpep_csr_if.sink    csr_port
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   item_type     push_item;
   item_type     pop_item;

   ftpep_front u_front (
      .req_port  (req_port),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   ftpep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   ftpep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rsp_port  (rsp_port),
      .csr_port  (csr_port),
      .q_status  (q_status),
      .pop_item  (pop_item),
      .pop       (pop)
   );

   // Accepted results carry a nonzero address and port
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && (rsp_port.status == ST_OK)) |->
      ((rsp_port.ipv4_address != '0) && (rsp_port.port_number != '0)))
      else $error("accepted result with zero address or port");

   // Rejected results carry zero payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && (rsp_port.status != ST_OK)) |->
      ((rsp_port.ipv4_address == '0) && (rsp_port.port_number == '0)))
      else $error("rejected result with nonzero payload");

   // Reset leaves the queue empty and no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (q_status.empty && !rsp_port.valid))
      else $error("queue or result not cleared by reset");

   // The queue never reports empty and full together
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue both empty and full");

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for the extended-port argument parser (ftp_extended_port_parser).
// Uses ftpep_pkg and the ftpep_*_if channel interfaces. A directed table, then random
// texts under several idle settings, each result checked against a parse predictor.
`timescale 1ns / 100ps

module tb_top;
   import ftpep_pkg::*;

   localparam int RAND_ITEMS     = 1100;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int N_DIR          = 26;

   // One parse result
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] addr;
      logic [15:0] port;
   } verdict_type;

   localparam verdict_type V_NONE    = '0;
   localparam verdict_type V_SYNTAX  = '{ST_SYNTAX, 32'd0, 16'd0};
   localparam verdict_type V_FAMILY  = '{ST_FAMILY, 32'd0, 16'd0};
   localparam verdict_type V_HANDOFF = '{ST_HANDOFF, 32'd0, 16'd0};

   // Directed row: text, byte replaced by zero (-1 none), v6 setting, typed result
   typedef struct {
      string       txt;
      int          zero_at;
      bit          v6;
      bit          typed;
      verdict_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   ftpep_req_if req_if();
   ftpep_rsp_if rsp_if();
   ftpep_csr_if csr_if();

   ftp_extended_port_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Parser state mirror
   logic [2:0]  p_phase;
   logic [7:0]  p_delim;
   logic [7:0]  p_family;
   logic [1:0]  p_octet_idx;
   logic [1:0]  p_sep;
   logic [16:0] p_accum;
   logic [31:0] p_addr;
   logic [1:0]  p_fail;
   bit          p_digit_seen;
   bit          p_v6;

   verdict_type verdict_q[$];
   verdict_type last_rsp;
   verdict_type predicted;
   logic [7:0]  text_q[$];

   int  errors = 0;
   int  rsp_seen = 0;
   int  texts_sent = 0;
   int  bytes_sent = 0;
   int  idle_cycles = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_off_pending = 1'b0;
   bit  cur_v6 = 1'b0;

   dir_row_type dir_rows [N_DIR] = '{
      '{"|1|10.0.0.1|21|",           -1, 1'b0, 1'b1, '{ST_OK, 32'h0A000001, 16'd21}},
      '{"|1|255,255,255,255|65535|", -1, 1'b0, 1'b1, '{ST_OK, 32'hFFFFFFFF, 16'd65535}},
      '{"|1|0.0.0.1|1|",             -1, 1'b0, 1'b1, '{ST_OK, 32'h00000001, 16'd1}},
      '{"|1|0.0.0.0|21|",            -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|256.1.1.1|21|",          -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1.2.3.4|65536|",         -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1.2.3.4|0|",             -1, 1'b0, 1'b1, V_SYNTAX},
      '{"7|1|1.2.3.4|21|",           -1, 1'b0, 1'b1, V_SYNTAX},
      '{".1.1.2.3.4.21.",            -1, 1'b0, 1'b1, V_SYNTAX},
      '{",1,1,2,3,4,21,",            -1, 1'b0, 1'b1, V_SYNTAX},
      '{"@",                          0, 1'b0, 1'b1, V_SYNTAX},
      '{"|2|1.2.3.4|21|",            -1, 1'b0, 1'b1, V_FAMILY},
      '{"||1.2.3.4|21|",             -1, 1'b0, 1'b1, V_FAMILY},
      '{"|999|1.2.3.4|21|",          -1, 1'b0, 1'b1, V_FAMILY},
      '{"|1|1.2,3.4|21|",            -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1..2.3.4|21|",           -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1.2.3|4|",               -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1.2.3.4|99999999|",      -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1x|1.2.3.4|21|",           -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1.2.3.4|2a|",            -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1.2.3",                  -1, 1'b0, 1'b1, V_SYNTAX},
      '{"|1|1.2.3.4.99,7|80|end",    -1, 1'b0, 1'b0, V_NONE},
      '{"|1|1.2.3.4|21|@junk",       14, 1'b0, 1'b0, V_NONE},
      '{"\3771\377001.02.3.4\37780\377", -1, 1'b1, 1'b0, V_NONE},
      '{"|2|::1|21|",                -1, 1'b1, 1'b1, V_HANDOFF},
      '{"|1|1.2.3.4|21|",            -1, 1'b1, 1'b1, '{ST_OK, 32'h01020304, 16'd21}}
   };

   // ---------------------------------------------------------------- predictor

   function automatic void clear_parse();
      p_phase      = PH_DELIM;
      p_delim      = '0;
      p_family     = '0;
      p_octet_idx  = '0;
      p_sep        = SEP_NONE;
      p_accum      = '0;
      p_addr       = '0;
      p_fail       = ST_OK;
      p_digit_seen = 1'b0;
   endfunction

   function automatic void fail_with(input logic [1:0] st);
      p_fail  = st;
      p_phase = PH_FAILED;
   endfunction

   // acc * 10 + digit, clipped at lim
   function automatic logic [16:0] mac10(input logic [16:0] acc, input logic [7:0] ch,
                                         input logic [16:0] lim);
      int unsigned v;
      v = 32'(acc) * 10 + 32'(ch) - 32'(CH_ZERO);
      return (v > 32'(lim)) ? lim : v[16:0];
   endfunction

   function automatic bit commit_octet();
      if (!p_digit_seen || p_accum > OCTET_MAX) begin
         fail_with(ST_SYNTAX);
         return 1'b0;
      end
      p_addr       = {p_addr[23:0], p_accum[7:0]};
      p_octet_idx  = p_octet_idx + 2'd1;
      p_accum      = '0;
      p_digit_seen = 1'b0;
      return 1'b1;
   endfunction

   function automatic void enter_port();
      if (p_addr == '0) begin
         fail_with(ST_SYNTAX);
      end else begin
         p_accum = '0;
         p_phase = PH_PORT;
      end
   endfunction

   // Advance the parse by one byte; returns 1 when the byte ends the text
   function automatic bit parse_byte(input logic [7:0] c, input bit is_last,
                                     output verdict_type v);
      bit         is_dig;
      bit         is_sep;
      logic [1:0] kind;
      v = V_NONE;
      if (p_phase == PH_DRAIN) begin
         if (is_last) clear_parse();
         return 1'b0;
      end
      if (c != 8'h00) begin
         is_dig = (c >= CH_ZERO && c <= CH_NINE);
         is_sep = (c == CH_DOT || c == CH_COMMA);
         case (p_phase)
            PH_DELIM: begin
               if (is_dig || is_sep) begin
                  fail_with(ST_SYNTAX);
               end else begin
                  p_delim = c;
                  p_phase = PH_FAMILY;
               end
            end
            PH_FAMILY: begin
               if (is_dig) begin
                  p_family = 8'(mac10({9'd0, p_family}, c, FAMILY_MAX));
               end else if (c == p_delim) begin
                  if (p_family == FAMILY_V6 && p_v6) fail_with(ST_HANDOFF);
                  else if (p_family != FAMILY_V4) fail_with(ST_FAMILY);
                  else p_phase = PH_OCTETS;
               end else begin
                  fail_with(ST_SYNTAX);
               end
            end
            PH_OCTETS: begin
               if (is_dig) begin
                  p_accum      = mac10(p_accum, c, ACC_MAX);
                  p_digit_seen = 1'b1;
               end else if (is_sep) begin
                  kind = (c == CH_COMMA) ? SEP_COMMA : SEP_DOT;
                  if (p_octet_idx == 2'd3) begin
                     if (commit_octet()) p_phase = PH_TAIL;
                  end else if (p_sep != SEP_NONE && p_sep != kind) begin
                     fail_with(ST_SYNTAX);
                  end else begin
                     p_sep = kind;
                     void'(commit_octet());
                  end
               end else if (c == p_delim && p_octet_idx == 2'd3) begin
                  if (commit_octet()) enter_port();
               end else begin
                  fail_with(ST_SYNTAX);
               end
            end
            PH_TAIL: begin
               // digits and separators after the fourth octet are skipped
               if (c == p_delim) enter_port();
               else if (!is_dig && !is_sep) fail_with(ST_SYNTAX);
            end
            PH_PORT: begin
               if (is_dig) begin
                  p_accum = mac10(p_accum, c, ACC_MAX);
               end else if (c == p_delim) begin
                  if (p_accum == '0 || p_accum > PORT_MAX) fail_with(ST_SYNTAX);
                  else p_phase = PH_DONE;
               end else begin
                  fail_with(ST_SYNTAX);
               end
            end
            default: ;
         endcase
         if (!is_last) return 1'b0;
      end
      if (p_phase == PH_DONE) begin
         v.status = ST_OK;
         v.addr   = p_addr;
         v.port   = p_accum[15:0];
      end else begin
         v.status = (p_phase == PH_FAILED) ? p_fail : ST_SYNTAX;
      end
      clear_parse();
      if (!is_last) p_phase = PH_DRAIN;
      return 1'b1;
   endfunction

   function automatic void check_fields(input verdict_type want, input verdict_type got);
      if (got.status !== want.status) begin
         $display("%0t: status mismatch, expected %0d, actual %0d",
                  $time, want.status, got.status);
         errors++;
      end
      if (got.addr !== want.addr) begin
         $display("%0t: ipv4_address mismatch, expected %h, actual %h",
                  $time, want.addr, got.addr);
         errors++;
      end
      if (got.port !== want.port) begin
         $display("%0t: port_number mismatch, expected %0d, actual %0d",
                  $time, want.port, got.port);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) p_v6 = csr_if.v6_enabled;
         if (req_if.valid && req_if.ready) begin
            if (parse_byte(req_if.text_byte, req_if.last_byte, predicted))
               verdict_q.push_back(predicted);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            last_rsp = '{rsp_if.status, rsp_if.ipv4_address, rsp_if.port_number};
            rsp_seen++;
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result, status %0d address %h port %0d",
                        $time, last_rsp.status, last_rsp.addr, last_rsp.port);
               errors++;
            end else begin
               check_fields(verdict_q.pop_front(), last_rsp);
            end
         end
         // watchdog on cycles with no handshake at all
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            // long hold-off so the block backs up into its input
            hold_off_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic send_byte(input logic [7:0] b, input bit is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.text_byte <= b;
      req_if.last_byte <= is_last;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // Every text ends with last_byte set, so each one yields exactly one result.
   // Valid stays up between texts; the sender drops it only when it pauses.
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
      texts_sent++;
      bytes_sent += text_q.size();
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      wait (rsp_seen == texts_sent);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_v6(input bit val);
      csr_if.valid      <= 1'b1;
      csr_if.v6_enabled <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      cur_v6 = val;
   endtask

   function automatic void push_num(input int unsigned val, input int pad);
      string s;
      s = $sformatf("%0d", val);
      repeat (pad) text_q.push_back(CH_ZERO);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   // Mostly well-formed arguments with random content, some noise and damage
   function automatic void gen_text();
      int          r;
      int          pos;
      int unsigned val;
      bit          zero_addr;
      logic [7:0]  d;
      logic [7:0]  sep_ch;
      logic [7:0]  alt_ch;
      text_q.delete();
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(99) < 3) begin
            d = $urandom_range(1) ? CH_COMMA : 8'(CH_ZERO + $urandom_range(9));
         end else begin
            do d = 8'($urandom_range(1, 255));
            while ((d >= CH_ZERO && d <= CH_NINE) || d == CH_DOT || d == CH_COMMA);
         end
         text_q.push_back(d);
         r = $urandom_range(99);
         if (r < 80) push_num(1, 0);
         else if (r < 88) push_num(2, 0);
         else if (r >= 92) push_num($urandom_range(999), $urandom_range(1));
         text_q.push_back(d);
         sep_ch    = $urandom_range(1) ? CH_DOT : CH_COMMA;
         alt_ch    = (sep_ch == CH_DOT) ? CH_COMMA : CH_DOT;
         zero_addr = ($urandom_range(99) < 3);
         for (int i = 0; i < 4; i++) begin
            r = $urandom_range(99);
            if (zero_addr || r < 10) val = 0;
            else if (r < 20) val = 255;
            else if (r < 93) val = $urandom_range(255);
            else val = $urandom_range(256, 999999);
            if ($urandom_range(99) >= 2)
               push_num(val, ($urandom_range(99) < 5) ? $urandom_range(1, 3) : 0);
            if (i < 3) text_q.push_back(($urandom_range(99) < 4) ? alt_ch : sep_ch);
         end
         // separator after the last octet, then skipped digits and separators
         if ($urandom_range(99) < 15) begin
            text_q.push_back($urandom_range(1) ? sep_ch : alt_ch);
            repeat ($urandom_range(4))
               text_q.push_back($urandom_range(2) == 0 ? alt_ch : 8'(CH_ZERO + $urandom_range(9)));
         end
         text_q.push_back(d);
         r = $urandom_range(99);
         if (r < 6) val = 0;
         else if (r < 14) val = 65535;
         else if (r < 20) val = $urandom_range(65536, 999999);
         else if (r < 24) val = 1;
         else val = $urandom_range(1, 65535);
         push_num(val, 0);
         text_q.push_back(d);
         if ($urandom_range(99) < 10)
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(99) < 10)
         text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(99) < 5) begin
         pos = $urandom_range(1, text_q.size());
         while (text_q.size() > pos) void'(text_q.pop_back());
      end
      // zero byte ends the text early; anything after it is drained
      if ($urandom_range(99) < 10) begin
         pos = $urandom_range(text_q.size());
         text_q.insert(pos, 8'h00);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   initial begin
      clear_parse();
      p_v6              = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.text_byte  = '0;
      req_if.last_byte  = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.v6_enabled = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_v6(1'b0);

      // directed table
      foreach (dir_rows[k]) begin
         if (dir_rows[k].v6 != cur_v6) begin
            wait_drained();
            write_v6(dir_rows[k].v6);
         end
         text_q.delete();
         for (int i = 0; i < dir_rows[k].txt.len(); i++)
            text_q.push_back((i == dir_rows[k].zero_at) ? 8'h00 : dir_rows[k].txt[i]);
         send_text();
         if (dir_rows[k].typed) begin
            req_if.valid <= 1'b0;
            wait (rsp_seen == texts_sent);
            check_fields(dir_rows[k].want, last_rsp);
         end
      end

      // random phases under different idle settings
      bytes_sent = 0;
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         write_v6(ph % 2 == 0);
         case (ph)
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            3: begin idle_pct = 12; stall_pct = 12; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         if (ph == 2) begin
            // short texts pile up behind a stalled result channel
            hold_off_pending = 1'b1;
            repeat (24) begin
               text_q.delete();
               repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
               send_text();
            end
            wait_drained();
         end
         while (bytes_sent < (ph + 1) * RAND_ITEMS / 5) begin
            gen_text();
            send_text();
            if ($urandom_range(99) < 2) wait_drained();
         end
      end

      wait_drained();
      if (errors == 0 && verdict_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
rtl/core/ftpep_pkg.sv
rtl/core/ftpep_if.sv
rtl/core/ftpep_front.sv
rtl/core/ftpep_queue.sv
rtl/core/ftpep_back.sv
rtl/core/ftp_extended_port_parser.sv
verif/tb_top.sv
